// ===== src/pft_pkg.sv =====
// Shared types, codes and defaults for the pattern frequency table.
package pft_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int COUNT_BITS    = 16;
  localparam int KEY_BITS      = 64;
  localparam int IDX_BITS      = 7;
  localparam int OCC_BITS      = 16;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } pft_op_e;

  typedef enum logic [2:0] {
    ST_HIT    = 3'd0,
    ST_INSERT = 3'd1,
    ST_DROP   = 3'd2,
    ST_READ   = 3'd3,
    ST_CLEAR  = 3'd4
  } pft_status_e;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [KEY_BITS-1:0] pattern_key;
    logic [IDX_BITS-1:0] slot_select;
  } pft_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [IDX_BITS-1:0] slot_index;
    logic [OCC_BITS-1:0] occurrences;
    logic [KEY_BITS-1:0] stored_key;
    logic                slot_valid;
  } pft_result_t;

  // controller to datapath
  typedef struct packed {
    logic        load;
    logic        eval;
    logic        rd_scan;
    logic        rd_sel;
    logic        wr_zero;
    logic        wr_hit;
    logic        wr_ins;
    logic        emit;
    pft_status_e status;
  } pft_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic free_any;
    logic data_last;
    logic issue_done;
    logic addr_last;
  } pft_stat_t;

endpackage

// ===== src/pattern_frequency_table.sv =====
// Top level of the pattern frequency table: sequencer plus datapath.
// Add: a miss scans the whole table before the result, a hit in slot k ends the scan at slot k.
// Read and clear each give one result; unused opcode: no result.
// One item at a time; busy drops in the cycle the result strobe rises.
// After reset the table memory is wiped, one slot per cycle
// with busy high; results are never stalled by the receiver.
module pattern_frequency_table #(
  parameter int TableEntries = pft_pkg::TABLE_ENTRIES,
  parameter int CountBits    = pft_pkg::COUNT_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  pft_pkg::pft_item_t   item_i,
  output pft_pkg::pft_result_t result_o,
  output logic                 done_o
);

  pft_pkg::pft_cmd_t  cmd;
  pft_pkg::pft_stat_t stat;

  pft_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (item_i.opcode),
    .stat_i   (stat),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  pft_dp #(
    .TableEntries (TableEntries),
    .CountBits    (CountBits)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (result_o),
    .done_o   (done_o)
  );

endmodule

// ===== src/pft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pft_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pft_ctrl.sv =====
// Sequencer for the pattern frequency table: scan, update, read and clear control.
module pft_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [1:0]         opcode_i,
  input  pft_pkg::pft_stat_t stat_i,
  output logic               busy,
  output pft_pkg::pft_cmd_t  cmd_o
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_HIT    = 4'd3;
  localparam logic [3:0] S_INS    = 4'd4;
  localparam logic [3:0] S_DROP   = 4'd5;
  localparam logic [3:0] S_CLR    = 4'd6;
  localparam logic [3:0] S_RDSEL  = 4'd7;
  localparam logic [3:0] S_RDWAIT = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        // wipe every slot after reset
        cmd_o.wr_zero = 1'b1;
        if (stat_i.addr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          case (opcode_i)
            pft_pkg::OP_ADD:   state_d = S_SCAN;
            pft_pkg::OP_READ:  state_d = S_RDSEL;
            pft_pkg::OP_CLEAR: state_d = S_CLR;
            default:           state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.eval    = 1'b1;
        cmd_o.rd_scan = !stat_i.issue_done;
        if (stat_i.hit) begin
          state_d = S_HIT;
        end else if (stat_i.data_last) begin
          state_d = stat_i.free_any ? S_INS : S_DROP;
        end
      end
      S_HIT: begin
        cmd_o.wr_hit = 1'b1;
        cmd_o.emit   = 1'b1;
        cmd_o.status = pft_pkg::ST_HIT;
        state_d      = S_IDLE;
      end
      S_INS: begin
        cmd_o.wr_ins = 1'b1;
        cmd_o.emit   = 1'b1;
        cmd_o.status = pft_pkg::ST_INSERT;
        state_d      = S_IDLE;
      end
      S_DROP: begin
        cmd_o.emit   = 1'b1;
        cmd_o.status = pft_pkg::ST_DROP;
        state_d      = S_IDLE;
      end
      S_CLR: begin
        cmd_o.wr_zero = 1'b1;
        if (stat_i.addr_last) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = pft_pkg::ST_CLEAR;
          state_d      = S_IDLE;
        end
      end
      S_RDSEL: begin
        cmd_o.rd_sel = 1'b1;
        state_d      = S_RDWAIT;
      end
      S_RDWAIT: begin
        cmd_o.emit   = 1'b1;
        cmd_o.status = pft_pkg::ST_READ;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

`ifndef SYNTH
  a_no_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !cmd_o.emit)
    else $error("result emitted from idle");

  a_emit_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (state_q == S_IDLE))
    else $error("sequencer not idle after result");

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (state_q == S_IDLE) && start)
    else $error("item loaded outside idle");
`endif

endmodule

// ===== src/pft_dp.sv =====
// Datapath: table memory, scan address, match compare, count update and result register.
module pft_dp #(
  parameter int TableEntries = pft_pkg::TABLE_ENTRIES,
  parameter int CountBits    = pft_pkg::COUNT_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pft_pkg::pft_item_t  item_i,
  input  pft_pkg::pft_cmd_t   cmd_i,
  output pft_pkg::pft_stat_t  stat_o,
  output pft_pkg::pft_result_t result_o,
  output logic                done_o
);

  localparam int AddrW  = $clog2(TableEntries);
  localparam int CntW   = AddrW + 1;
  localparam int KeyW   = pft_pkg::KEY_BITS;
  localparam int EntryW = 1 + KeyW + CountBits;

  function automatic logic [pft_pkg::OCC_BITS-1:0] occ_sat(input logic [CountBits-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  logic [KeyW-1:0]               key_q;
  logic [pft_pkg::IDX_BITS-1:0]  sel_q;
  logic [CntW-1:0]               addr_q;
  logic                          pend_q;
  logic [AddrW-1:0]              pidx_q;
  logic                          free_q;
  logic [AddrW-1:0]              free_idx_q;
  logic [AddrW-1:0]              hit_idx_q;
  logic [CountBits-1:0]          hit_cnt_q;
  pft_pkg::pft_result_t          res_q, res_d;
  logic                          done_q;

  logic                  we, re;
  logic [AddrW-1:0]      waddr, raddr;
  logic [EntryW-1:0]     wdata, rdata;
  logic                  ent_valid;
  logic [KeyW-1:0]       ent_key;
  logic [CountBits-1:0]  ent_cnt;
  logic [CountBits-1:0]  ent_cnt_inc;
  logic                  hit, free_now, sel_in_range;

  assign ent_valid   = rdata[EntryW-1];
  assign ent_key     = rdata[EntryW-2 -: KeyW];
  assign ent_cnt     = rdata[CountBits-1:0];
  assign ent_cnt_inc = (&ent_cnt) ? ent_cnt : ent_cnt + CountBits'(1);

  assign hit          = pend_q && ent_valid && (ent_key == key_q);
  assign free_now     = pend_q && !ent_valid;
  assign sel_in_range = (32'(sel_q) < 32'(TableEntries));

  // memory ports
  assign re    = cmd_i.rd_scan || cmd_i.rd_sel;
  assign raddr = cmd_i.rd_sel ? AddrW'(sel_q) : addr_q[AddrW-1:0];
  assign we    = cmd_i.wr_zero || cmd_i.wr_hit || cmd_i.wr_ins;

  always_comb begin
    waddr = addr_q[AddrW-1:0];
    wdata = '0;
    if (cmd_i.wr_hit) begin
      waddr = hit_idx_q;
      wdata = {1'b1, key_q, hit_cnt_q};
    end else if (cmd_i.wr_ins) begin
      waddr = free_idx_q;
      wdata = {1'b1, key_q, CountBits'(1)};
    end
  end

  pft_ram #(
    .Width (EntryW),
    .Depth (TableEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      pend_q <= 1'b0;
      free_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.load) begin
        addr_q <= '0;
        pend_q <= 1'b0;
        free_q <= 1'b0;
      end else begin
        pend_q <= cmd_i.rd_scan;
        if (cmd_i.rd_scan || cmd_i.wr_zero) begin
          addr_q <= addr_q + CntW'(1);
        end
        if (cmd_i.eval && free_now) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= item_i.pattern_key;
      sel_q <= item_i.slot_select;
    end
    pidx_q <= addr_q[AddrW-1:0];
    if (cmd_i.eval && free_now && !free_q) begin
      free_idx_q <= pidx_q;
    end
    if (cmd_i.eval && hit) begin
      hit_idx_q <= pidx_q;
      hit_cnt_q <= ent_cnt_inc;
    end
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    res_d        = '0;
    res_d.status = cmd_i.status;
    case (cmd_i.status)
      pft_pkg::ST_HIT: begin
        res_d.slot_index  = pft_pkg::IDX_BITS'(hit_idx_q);
        res_d.occurrences = occ_sat(hit_cnt_q);
        res_d.stored_key  = key_q;
        res_d.slot_valid  = 1'b1;
      end
      pft_pkg::ST_INSERT: begin
        res_d.slot_index  = pft_pkg::IDX_BITS'(free_idx_q);
        res_d.occurrences = pft_pkg::OCC_BITS'(1);
        res_d.stored_key  = key_q;
        res_d.slot_valid  = 1'b1;
      end
      pft_pkg::ST_READ: begin
        res_d.slot_index = sel_q;
        if (sel_in_range && ent_valid) begin
          res_d.occurrences = occ_sat(ent_cnt);
          res_d.stored_key  = ent_key;
          res_d.slot_valid  = 1'b1;
        end
      end
      default: begin
        res_d.slot_index = '0;
      end
    endcase
  end

  assign stat_o.hit        = hit;
  assign stat_o.free_any   = free_q || free_now;
  assign stat_o.data_last  = pend_q && (pidx_q == AddrW'(TableEntries - 1));
  assign stat_o.issue_done = (addr_q == CntW'(TableEntries));
  assign stat_o.addr_last  = (addr_q == CntW'(TableEntries - 1));

  assign result_o = res_q;
  assign done_o   = done_q;

`ifndef SYNTH
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.wr_zero, cmd_i.wr_hit, cmd_i.wr_ins}))
    else $error("more than one table write source");

  a_scan_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_scan |-> (addr_q < CntW'(TableEntries)))
    else $error("scan read beyond table");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_q.status == pft_pkg::ST_INSERT)) |->
      (res_q.occurrences == 16'd1) && res_q.slot_valid)
    else $error("insert result without count of one");

  a_insert_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_ins |-> free_q)
    else $error("insert without a free slot");
`endif

endmodule

// ===== tb/sv/pft_table_checker.sv =====
// Checker for the pattern frequency table: mirrors the table, predicts and compares results.
`timescale 1ns / 1ps
module pft_table_checker #(
  parameter int TableEntries = pft_pkg::TABLE_ENTRIES,
  parameter int CountBits    = pft_pkg::COUNT_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  pft_pkg::pft_item_t   item_i,
  input  pft_pkg::pft_result_t result_i,
  input  logic                 done_i,
  output int                   pending_o,
  output int                   fail_count_o
);

  localparam longint unsigned CountMax = (64'd1 << CountBits) - 1;
  localparam int              PrintCap = 40;

  // mirror of the table
  bit                           slot_used [TableEntries];
  logic [pft_pkg::KEY_BITS-1:0] slot_key  [TableEntries];
  longint unsigned              slot_hits [TableEntries];

  pft_pkg::pft_result_t table_answers [$];
  int                   fail_total;

  assign fail_count_o = fail_total;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_total < PrintCap) begin
      $display("ERROR @%0t: %s got %h expected %h", $time, what, got, want);
    end
    fail_total++;
  endtask

  function automatic pft_pkg::pft_result_t slot_report(input pft_pkg::pft_status_e st,
                                                       input int idx,
                                                       input longint unsigned cnt,
                                                       input logic [pft_pkg::KEY_BITS-1:0] key,
                                                       input logic valid);
    pft_pkg::pft_result_t r;
    r.status      = st;
    r.slot_index  = idx[pft_pkg::IDX_BITS-1:0];
    r.occurrences = (cnt > 64'hFFFF) ? {pft_pkg::OCC_BITS{1'b1}} : cnt[pft_pkg::OCC_BITS-1:0];
    r.stored_key  = key;
    r.slot_valid  = valid;
    return r;
  endfunction

  // Applies one transfer to the mirror; returns 1 when a result is due.
  function automatic bit tally_item(input pft_pkg::pft_item_t it,
                                    output pft_pkg::pft_result_t res);
    int hit_at;
    int free_at;
    hit_at  = -1;
    free_at = -1;
    res     = '0;
    case (it.opcode)
      pft_pkg::OP_ADD: begin
        for (int i = 0; i < TableEntries; i++) begin
          if (hit_at < 0 && slot_used[i] && slot_key[i] == it.pattern_key) hit_at = i;
          if (free_at < 0 && !slot_used[i]) free_at = i;
        end
        if (hit_at >= 0) begin
          if (slot_hits[hit_at] < CountMax) slot_hits[hit_at]++;
          res = slot_report(pft_pkg::ST_HIT, hit_at, slot_hits[hit_at], slot_key[hit_at],
                            1'b1);
        end else if (free_at >= 0) begin
          slot_used[free_at] = 1'b1;
          slot_key[free_at]  = it.pattern_key;
          slot_hits[free_at] = 1;
          res = slot_report(pft_pkg::ST_INSERT, free_at, 1, it.pattern_key, 1'b1);
        end else begin
          res = slot_report(pft_pkg::ST_DROP, 0, 0, '0, 1'b0);
        end
        return 1'b1;
      end
      pft_pkg::OP_READ: begin
        if (it.slot_select < TableEntries && slot_used[it.slot_select]) begin
          res = slot_report(pft_pkg::ST_READ, it.slot_select, slot_hits[it.slot_select],
                            slot_key[it.slot_select], 1'b1);
        end else begin
          res = slot_report(pft_pkg::ST_READ, it.slot_select, 0, '0, 1'b0);
        end
        return 1'b1;
      end
      pft_pkg::OP_CLEAR: begin
        for (int i = 0; i < TableEntries; i++) slot_used[i] = 1'b0;
        res = slot_report(pft_pkg::ST_CLEAR, 0, 0, '0, 1'b0);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pft_pkg::pft_result_t want;
    pft_pkg::pft_result_t fresh;
    if (!rst_ni) begin
      for (int i = 0; i < TableEntries; i++) slot_used[i] = 1'b0;
      table_answers.delete();
      pending_o <= 0;
    end else begin
      // result first: a new transfer may be taken on the edge that ends the strobe
      if (done_i) begin
        if (table_answers.size() == 0) begin
          report_mismatch("result with nothing outstanding, status",
                          64'(result_i.status), '0);
        end else begin
          want = table_answers.pop_front();
          if (result_i.status !== want.status)
            report_mismatch("status", 64'(result_i.status), 64'(want.status));
          if (result_i.slot_index !== want.slot_index)
            report_mismatch("slot_index", 64'(result_i.slot_index), 64'(want.slot_index));
          if (result_i.occurrences !== want.occurrences)
            report_mismatch("occurrences", 64'(result_i.occurrences),
                            64'(want.occurrences));
          if (result_i.stored_key !== want.stored_key)
            report_mismatch("stored_key", result_i.stored_key, want.stored_key);
          if (result_i.slot_valid !== want.slot_valid)
            report_mismatch("slot_valid", 64'(result_i.slot_valid), 64'(want.slot_valid));
        end
      end
      if (start_i && !busy_i) begin
        if (tally_item(item_i, fresh)) table_answers.push_back(fresh);
      end
      pending_o <= table_answers.size();
    end
  end

endmodule

// ===== tb/sv/pattern_frequency_table_test.sv =====
// Testbench top for the pattern frequency table: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module pattern_frequency_table_test;

  localparam int         TableEntries = pft_pkg::TABLE_ENTRIES;
  localparam int         PoolSize     = 96;
  localparam int         PhaseItems   = 105;
  localparam int         StallLimit   = 4000;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  pft_pkg::pft_item_t   item_i;
  pft_pkg::pft_result_t result_o;
  logic                 done_o;
  int                   pending;
  int                   fails;

  int          idle_pct;
  int          items_sent;
  int          quiet_cycles;
  int          written_upto;   // slots below this have been written since reset
  logic [63:0] held_keys [$];
  bit          in_table [bit [63:0]];
  logic [63:0] key_pool [PoolSize];

  pattern_frequency_table dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .result_o (result_o),
    .done_o   (done_o)
  );

  pft_table_checker #(
    .TableEntries (TableEntries),
    .CountBits    (pft_pkg::COUNT_BITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .item_i       (item_i),
    .result_i     (result_o),
    .done_i       (done_o),
    .pending_o    (pending),
    .fail_count_o (fails)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // counts cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("pattern_frequency_table regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send(input pft_pkg::pft_item_t it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      // mostly short gaps, now and then long enough to leave the block idle
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 180) : $urandom_range(1, 4))
        @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic offer_key(input logic [63:0] key);
    pft_pkg::pft_item_t it;
    if (!in_table.exists(key) && held_keys.size() < TableEntries) begin
      in_table[key] = 1'b1;
      held_keys.push_back(key);
      if (held_keys.size() > written_upto) written_upto = held_keys.size();
    end
    it.opcode      = pft_pkg::OP_ADD;
    it.pattern_key = key;
    it.slot_select = pft_pkg::IDX_BITS'($urandom);
    send(it);
  endtask

  task automatic read_slot(input int slot);
    pft_pkg::pft_item_t it;
    it.opcode      = pft_pkg::OP_READ;
    it.pattern_key = rand64();
    it.slot_select = pft_pkg::IDX_BITS'(slot);
    send(it);
  endtask

  // only slots written since reset are read
  task automatic read_random();
    if (written_upto == 0) offer_key(rand64());
    else read_slot($urandom_range(0, written_upto - 1));
  endtask

  task automatic clear_table();
    pft_pkg::pft_item_t it;
    in_table.delete();
    held_keys.delete();
    it.opcode      = pft_pkg::OP_CLEAR;
    it.pattern_key = rand64();
    it.slot_select = pft_pkg::IDX_BITS'($urandom);
    send(it);
  endtask

  task automatic send_unused(input logic [63:0] key,
                             input logic [pft_pkg::IDX_BITS-1:0] sel);
    pft_pkg::pft_item_t it;
    it.opcode      = OP_UNUSED;
    it.pattern_key = key;
    it.slot_select = sel;
    send(it);
  endtask

  function automatic logic [63:0] held_pick();
    return held_keys[$urandom_range(0, held_keys.size() - 1)];
  endfunction

  // fills every slot, then pushes drops, hits and reads against the full table
  task automatic fill_table();
    int pick;
    clear_table();
    while (held_keys.size() < TableEntries) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) offer_key(rand64());
      else if (pick < 90 && held_keys.size() != 0) offer_key(held_pick());
      else if (pick < 97) read_random();
      else send_unused(rand64(), pft_pkg::IDX_BITS'($urandom));
    end
    repeat (12) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) offer_key(rand64());
      else if (pick < 70) offer_key(held_pick());
      else read_random();
    end
    read_slot(TableEntries - 1);
  endtask

  // short run over a key set of 4, 24 or 96 keys so counts climb
  task automatic mixed_run();
    int span;
    int len;
    int pick;
    clear_table();
    case ($urandom_range(0, 2))
      0:       span = 4;
      1:       span = 24;
      default: span = PoolSize;
    endcase
    len = $urandom_range(20, 40);
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) offer_key(key_pool[$urandom_range(0, span - 1)]);
      else if (pick < 62) offer_key(rand64());
      else if (pick < 85) read_random();
      else if (pick < 93) send_unused(rand64(), pft_pkg::IDX_BITS'($urandom));
      else clear_table();
    end
  endtask

  initial begin : stimulus
    int phase_end;
    start        = 1'b0;
    item_i       = '0;
    rst_ni       = 1'b0;
    idle_pct     = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    written_upto = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: key extremes, repeats, reads of full and empty slots, unused opcode
    offer_key(64'h0);
    offer_key({64{1'b1}});
    offer_key(64'h0);
    offer_key(64'h0);
    read_slot(0);
    read_slot(1);
    send_unused(64'h0, '0);
    offer_key(64'h0123_4567_89AB_CDEF);
    offer_key(64'h8000_0000_0000_0000);
    offer_key(64'h0000_0000_0000_0001);
    read_slot(4);
    clear_table();
    read_slot(0);
    read_slot(4);
    offer_key({64{1'b1}});
    read_slot(0);
    send_unused({64{1'b1}}, {pft_pkg::IDX_BITS{1'b1}});
    offer_key(64'hAAAA_AAAA_5555_5555);
    offer_key({64{1'b1}});
    clear_table();

    foreach (key_pool[i]) key_pool[i] = rand64();

    // phases: no gaps, sender idle 67 %, receiver stall (no effect, results
    // cannot be held off), both at 21 % which leaves the sender at 21 %
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       idle_pct = 0;
        1:       idle_pct = 67;
        2:       idle_pct = 0;
        default: idle_pct = 21;
      endcase
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 2) == 0) fill_table();
        else mixed_run();
      end
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (TableEntries + 8) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("pattern_frequency_table regression: pass");
    end else begin
      $display("pattern_frequency_table regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pft_pkg.sv
src/pft_ram.sv
src/pft_ctrl.sv
src/pft_dp.sv
src/pattern_frequency_table.sv
tb/sv/pft_table_checker.sv
tb/sv/pattern_frequency_table_test.sv
